/* design/mar_pkg.sv */
package mar_pkg;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_X_START  = 3'd0;
    localparam cfg_index_t CFG_X_END    = 3'd1;
    localparam cfg_index_t CFG_Y_START  = 3'd2;
    localparam cfg_index_t CFG_Y_END    = 3'd3;
    localparam cfg_index_t CFG_X_STEP   = 3'd4;
    localparam cfg_index_t CFG_Y_STEP   = 3'd5;
    localparam cfg_index_t CFG_MAX_ITER = 3'd6;

    // escape threshold on x2 + y2; |x| or |y| at or above MAG_LIMIT escapes for sure
    localparam int ESC_LIMIT = 800;
    localparam int MAG_LIMIT = 400;
    localparam int MAX_COUNT = 19;

    // ceil(2^25 / 100) == ceil(2^26 / 200); exact for operands below 2^18
    localparam logic [18:0] RECIP = 19'd335545;

    localparam logic [6:0] NL_CHAR = 7'd10;

    typedef struct packed {
        logic       done;
        logic [4:0] count;
    } mar_status_t;

    function automatic logic [10:0] div_by_100(input logic [17:0] n);
        logic [36:0] p;
        p = 37'(n) * 37'(RECIP);
        return p[35:25];
    endfunction

    function automatic logic [10:0] div_by_200(input logic [17:0] n);
        logic [36:0] p;
        p = 37'(n) * 37'(RECIP);
        return p[36:26];
    endfunction

    function automatic logic [4:0] esc_count(input logic [7:0] iter);
        return (iter > 8'(MAX_COUNT)) ? 5'd0 : iter[4:0];
    endfunction

    function automatic logic [6:0] glyph(input logic [4:0] count);
        logic [6:0] g;
        unique case (count)
            5'd0:                      g = 7'h20;  // ' '
            5'd1:                      g = 7'h2E;  // '.'
            5'd2:                      g = 7'h3A;  // ':'
            5'd3:                      g = 7'h2D;  // '-'
            5'd4:                      g = 7'h3D;  // '='
            5'd5:                      g = 7'h2B;  // '+'
            5'd6:                      g = 7'h2A;  // '*'
            5'd7:                      g = 7'h23;  // '#'
            5'd8, 5'd9, 5'd10:         g = 7'h25;  // '%'
            5'd11, 5'd12, 5'd13, 5'd14: g = 7'h24; // '$'
            default:                   g = 7'h40;  // '@'
        endcase
        return g;
    endfunction

endpackage

/* design/mar_escape_unit.sv */
module mar_escape_unit
    import mar_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic [7:0]                   max_iter,
    output mar_status_t                  status
);

    localparam int ZW = ((COORD_BITS > 11) ? COORD_BITS : 11) + 2;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_SQX  = 5'b00010,
        PH_SQY  = 5'b00100,
        PH_XY   = 5'b01000,
        PH_UPD  = 5'b10000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic signed [ZW-1:0] x_reg, x_next;
    logic signed [ZW-1:0] y_reg, y_next;
    logic [7:0]         iter_reg, iter_next;
    logic [17:0]        prod_reg, prod_next;
    logic [10:0]        x2_reg, x2_next;
    logic [10:0]        y2_reg, y2_next;
    logic               neg_reg, neg_next;
    mar_status_t        status_reg, status_next;

    logic [ZW-1:0]      ax, ay;
    logic [8:0]         ax9, ay9;
    logic [11:0]        sum;
    logic [10:0]        q;
    logic signed [ZW-1:0] qz;

    assign ax  = x_reg[ZW-1] ? (~x_reg + 1'b1) : x_reg;
    assign ay  = y_reg[ZW-1] ? (~y_reg + 1'b1) : y_reg;
    assign ax9 = ax[8:0];
    assign ay9 = ay[8:0];
    assign sum = {1'b0, x2_reg} + {1'b0, y2_reg};
    assign q   = div_by_100(prod_reg);
    assign qz  = $signed(ZW'(q));

    always_comb
    begin
        phase_next  = phase_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        iter_next   = iter_reg;
        prod_next   = prod_reg;
        x2_next     = x2_reg;
        y2_next     = y2_reg;
        neg_next    = neg_reg;
        status_next = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    x_next     = '0;
                    y_next     = '0;
                    iter_next  = '0;
                    phase_next = PH_SQX;
                end
            end
            PH_SQX:
            begin
                if (iter_reg == max_iter)
                begin
                    status_next.done = 1'b1;
                    phase_next       = PH_IDLE;
                end
                else if (ax >= ZW'(MAG_LIMIT) || ay >= ZW'(MAG_LIMIT))
                begin
                    status_next.done  = 1'b1;
                    status_next.count = esc_count(iter_reg);
                    phase_next        = PH_IDLE;
                end
                else
                begin
                    prod_next  = 18'(ax9) * 18'(ax9);
                    phase_next = PH_SQY;
                end
            end
            PH_SQY:
            begin
                x2_next    = div_by_200(prod_reg);
                prod_next  = 18'(ay9) * 18'(ay9);
                phase_next = PH_XY;
            end
            PH_XY:
            begin
                y2_next    = div_by_200(prod_reg);
                prod_next  = 18'(ax9) * 18'(ay9);
                neg_next   = x_reg[ZW-1] ^ y_reg[ZW-1];
                phase_next = PH_UPD;
            end
            PH_UPD:
            begin
                if (sum >= 12'(ESC_LIMIT))
                begin
                    status_next.done  = 1'b1;
                    status_next.count = esc_count(iter_reg);
                    phase_next        = PH_IDLE;
                end
                else
                begin
                    y_next     = (neg_reg ? -qz : qz) + ZW'(cy);
                    x_next     = $signed(ZW'(x2_reg)) - $signed(ZW'(y2_reg)) + ZW'(cx);
                    iter_next  = iter_reg + 8'd1;
                    phase_next = PH_SQX;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            status_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        iter_reg <= iter_next;
        prod_reg <= prod_next;
        x2_reg   <= x2_next;
        y2_reg   <= y2_next;
        neg_reg  <= neg_next;
    end

    assign status = status_reg;

endmodule

/* design/mandelbrot_ascii_raster_unit.sv */
// Mandelbrot raster glyph generator. Each input beat produces the glyph of the
// next raster point, followed by a newline beat when that point closes a row;
// restart in the input beat jumps back to the first point of the frame. The
// escape iteration runs on one shared unit (a small multiplier followed by a
// reciprocal divide-by-constant stage) that squares x, squares y, forms the
// cross product and updates x and y in each iteration, until the point escapes
// or reaches the iteration limit (20 by default); a newline adds one beat.
// The block accepts no new beat until the previous point has been handed to
// the output register. An empty frame answers each beat with a single newline
// marked as frame end. Configuration may be written only while idle.
module mandelbrot_ascii_raster_unit
    import mar_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [6:0] char_code, [11:7] escape_count
    output logic [1:0]            m_tuser,   // [0] row_end, [1] frame_end
    output logic                  m_tlast
);

    localparam int XW = COORD_BITS + 2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CALC  = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_GLYPH = 5'b01000,
        ST_NL    = 5'b10000
    } state_t;

    logic signed [COORD_BITS-1:0] x_start_reg, x_end_reg, y_start_reg, y_end_reg;
    logic [7:0]                   x_step_reg, y_step_reg, max_iter_reg;

    state_t                       state_reg, state_next;
    logic signed [COORD_BITS-1:0] cur_real_reg, cur_real_next;
    logic signed [COORD_BITS-1:0] cur_imag_reg, cur_imag_next;
    logic [4:0]                   count_reg, count_next;
    logic                         nl_fe_reg, nl_fe_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [6:0]                   char_reg, char_next;
    logic [4:0]                   cnt_reg, cnt_next;
    logic                         row_reg, row_next;
    logic                         fe_reg, fe_next;
    logic                         last_reg, last_next;

    mar_status_t                  eng_status;
    logic                         eng_start;
    logic                         out_free;
    logic                         empty_frame, stale;
    logic signed [XW-1:0]         next_real, next_imag;
    logic                         col_more, frame_done;

    mar_escape_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_escape (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (eng_start),
        .cx       (cur_real_reg),
        .cy       (cur_imag_reg),
        .max_iter (max_iter_reg),
        .status   (eng_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg  <= COORD_BITS'(-500);
            x_end_reg    <= COORD_BITS'(300);
            y_start_reg  <= COORD_BITS'(240);
            y_end_reg    <= COORD_BITS'(-250);
            x_step_reg   <= 8'd7;
            y_step_reg   <= 8'd15;
            max_iter_reg <= 8'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_START:  x_start_reg  <= $signed(cfg_data);
                CFG_X_END:    x_end_reg    <= $signed(cfg_data);
                CFG_Y_START:  y_start_reg  <= $signed(cfg_data);
                CFG_Y_END:    y_end_reg    <= $signed(cfg_data);
                CFG_X_STEP:   x_step_reg   <= cfg_data[7:0];
                CFG_Y_STEP:   y_step_reg   <= cfg_data[7:0];
                CFG_MAX_ITER: max_iter_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign eng_start   = (state_reg == ST_CALC);
    assign empty_frame = (x_start_reg >= x_end_reg) || (y_start_reg <= y_end_reg);
    assign stale       = (cur_real_reg >= x_end_reg) || (cur_imag_reg <= y_end_reg);
    assign next_real   = XW'(cur_real_reg) + $signed(XW'(x_step_reg));
    assign next_imag   = XW'(cur_imag_reg) - $signed(XW'(y_step_reg));
    assign col_more    = next_real < XW'(x_end_reg);
    assign frame_done  = next_imag <= XW'(y_end_reg);

    always_comb
    begin
        state_next    = state_reg;
        cur_real_next = cur_real_reg;
        cur_imag_next = cur_imag_reg;
        count_next    = count_reg;
        nl_fe_next    = nl_fe_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        char_next     = char_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        fe_next       = fe_reg;
        last_next     = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (empty_frame)
                    begin
                        cur_real_next = x_start_reg;
                        cur_imag_next = y_start_reg;
                        nl_fe_next    = 1'b1;
                        state_next    = ST_NL;
                    end
                    else
                    begin
                        if (s_tdata[0] || stale)
                        begin
                            cur_real_next = x_start_reg;
                            cur_imag_next = y_start_reg;
                        end
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (eng_status.done)
                begin
                    count_next = eng_status.count;
                    state_next = ST_GLYPH;
                end
            end
            ST_GLYPH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    char_next     = glyph(count_reg);
                    cnt_next      = count_reg;
                    row_next      = 1'b0;
                    fe_next       = 1'b0;
                    last_next     = col_more;
                    if (col_more)
                    begin
                        cur_real_next = next_real[COORD_BITS-1:0];
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cur_real_next = x_start_reg;
                        cur_imag_next = frame_done ? y_start_reg : next_imag[COORD_BITS-1:0];
                        nl_fe_next    = frame_done;
                        state_next    = ST_NL;
                    end
                end
            end
            ST_NL:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    char_next     = NL_CHAR;
                    cnt_next      = '0;
                    row_next      = 1'b1;
                    fe_next       = nl_fe_reg;
                    last_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cur_real_reg <= COORD_BITS'(-500);
            cur_imag_reg <= COORD_BITS'(240);
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cur_real_reg <= cur_real_next;
            cur_imag_reg <= cur_imag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        nl_fe_reg <= nl_fe_next;
        char_reg  <= char_next;
        cnt_reg   <= cnt_next;
        row_reg   <= row_next;
        fe_reg    <= fe_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, cnt_reg, char_reg};
    assign m_tuser  = {fe_reg, row_reg};
    assign m_tlast  = last_reg;

endmodule

/* test/mandelbrot_ascii_raster_unit_test.sv */
`timescale 1ns / 100ps

module mandelbrot_ascii_raster_unit_test;
    import mar_pkg::*;

    localparam int COORD_W = 11;
    localparam int IDLE_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 1100;
    localparam int RANDOM_BEATS = 1050;
    localparam int REPORT_CAP = 40;
    localparam cfg_index_t CFG_UNUSED = 3'd7;
    localparam logic [6:0] NEWLINE = 7'd10;
    localparam string GLYPHS = " .:-=+*#%%%$$$$@@@@@";

    typedef struct packed {
        logic [6:0] char_code;
        logic [4:0] count;
        logic       row_end;
        logic       frame_end;
        logic       last;
    } glyph_beat_t;

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        cfg_index_t         index;
        logic [COORD_W-1:0] value;
        logic               restart;
        logic               typed;
        logic               two_beats;
        glyph_beat_t        first;
        glyph_beat_t        second;
    } stim_row_t;

    localparam glyph_beat_t NONE      = '0;
    localparam glyph_beat_t DOT_LAST  = {7'h2E, 5'd1, 1'b0, 1'b0, 1'b1};  // '.'
    localparam glyph_beat_t BLANK_MID = {7'h20, 5'd0, 1'b0, 1'b0, 1'b0};  // ' '
    localparam glyph_beat_t NL_FRAME  = {NEWLINE, 5'd0, 1'b1, 1'b1, 1'b1};

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    cfg_index_t         cfg_index;
    logic [COORD_W-1:0] cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;    // [0] restart
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;    // [6:0] char_code, [11:7] escape_count
    logic [1:0]         m_tuser;    // [0] row_end, [1] frame_end
    logic               m_tlast;

    // raster state mirror
    int col_first;
    int col_limit;
    int row_first;
    int row_limit;
    int col_step;
    int row_step;
    int iter_limit;
    int col_pos;
    int row_pos;

    glyph_beat_t expected_glyphs[$];
    int          mismatches;
    int          idle_cycles;
    int          sink_stall;
    bit          idles_on;

    mandelbrot_ascii_raster_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int escape_iters(int cx, int cy);
        longint x;
        longint y;
        longint x2;
        longint y2;
        longint ny;
        x = 0;
        y = 0;
        for (int i = 0; i < iter_limit; i++)
        begin
            x2 = (x * x) / 200;
            y2 = (y * y) / 200;
            if (x2 + y2 >= ESC_LIMIT)
                return (i > MAX_COUNT) ? 0 : i;
            ny = (x * y) / 100 + cy;
            x = x2 - y2 + cx;
            y = ny;
        end
        return 0;
    endfunction

    task automatic predict_point(input logic restart, output glyph_beat_t b0,
                                 output glyph_beat_t b1, output logic two);
        int  n;
        int  nxt;
        int  nimag;
        byte g;
        b0 = '0;
        b1 = '0;
        two = 1'b0;
        if (restart)
        begin
            col_pos = col_first;
            row_pos = row_first;
        end
        if (col_first >= col_limit || row_first <= row_limit)
        begin
            col_pos = col_first;
            row_pos = row_first;
            b0 = NL_FRAME;
            return;
        end
        if (col_pos >= col_limit || row_pos <= row_limit)
        begin
            col_pos = col_first;
            row_pos = row_first;
        end
        n = escape_iters(col_pos, row_pos);
        g = GLYPHS[n];
        b0.char_code = g[6:0];
        b0.count = 5'(n);
        b0.last = 1'b1;
        nxt = col_pos + col_step;
        if (nxt < col_limit)
        begin
            col_pos = nxt;
            return;
        end
        b0.last = 1'b0;
        col_pos = col_first;
        nimag = row_pos - row_step;
        two = 1'b1;
        b1.char_code = NEWLINE;
        b1.row_end = 1'b1;
        b1.frame_end = (nimag <= row_limit);
        b1.last = 1'b1;
        row_pos = b1.frame_end ? row_first : nimag;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [COORD_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_X_START:  col_first = $signed(val);
            CFG_X_END:    col_limit = $signed(val);
            CFG_Y_START:  row_first = $signed(val);
            CFG_Y_END:    row_limit = $signed(val);
            CFG_X_STEP:   col_step = int'(val[7:0]);
            CFG_Y_STEP:   row_step = int'(val[7:0]);
            CFG_MAX_ITER: iter_limit = int'(val[7:0]);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_glyphs.size() != 0)
            @(posedge clk);
    endtask

    function automatic int gap_len();
        int r;
        if (!idles_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(input logic restart, input int gap, input logic typed,
                             input logic two_typed, input glyph_beat_t t0,
                             input glyph_beat_t t1);
        glyph_beat_t p0;
        glyph_beat_t p1;
        logic        two;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, restart};
        do
            @(posedge clk);
        while (!s_tready);
        predict_point(restart, p0, p1, two);
        if (typed)
        begin
            p0 = t0;
            p1 = t1;
            two = two_typed;
        end
        expected_glyphs.push_back(p0);
        if (two)
            expected_glyphs.push_back(p1);
    endtask

    function automatic stim_row_t cfg_row(cfg_index_t idx, logic [COORD_W-1:0] val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.index = idx;
        r.value = val;
        return r;
    endfunction

    function automatic stim_row_t beat_row(logic restart, logic typed, logic two,
                                           glyph_beat_t b0, glyph_beat_t b1);
        stim_row_t r;
        r = '0;
        r.kind = ROW_BEAT;
        r.restart = restart;
        r.typed = typed;
        r.two_beats = two;
        r.first = b0;
        r.second = b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatches < REPORT_CAP)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : out_check
        glyph_beat_t got;
        glyph_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[6:0], m_tdata[11:7], m_tuser[0], m_tuser[1], m_tlast};
            if (expected_glyphs.size() == 0)
                report_mismatch("beat with nothing pending, char_code", -1, got.char_code);
            else
            begin
                want = expected_glyphs.pop_front();
                if (got.char_code != want.char_code)
                    report_mismatch("char_code", want.char_code, got.char_code);
                if (got.count != want.count)
                    report_mismatch("escape_count", want.count, got.count);
                if (got.row_end != want.row_end)
                    report_mismatch("row_end", want.row_end, got.row_end);
                if (got.frame_end != want.frame_end)
                    report_mismatch("frame_end", want.frame_end, got.frame_end);
                if (got.last != want.last)
                    report_mismatch("tlast", want.last, got.last);
            end
        end
    end

    always @(posedge clk)
    begin : sink
        logic ready_next;
        if (sink_stall > 0)
        begin
            sink_stall--;
            ready_next = 1'b0;
        end
        else if (idles_on && $urandom_range(0, 2) == 0)
        begin
            sink_stall = gap_len();
            ready_next = (sink_stall == 0);
        end
        else
            ready_next = 1'b1;
        m_tready <= ready_next;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t   script[$];
        int          sent;
        int          phase_beats;
        int          lo;
        int          hi;
        cfg_index_t  idx;
        logic [COORD_W-1:0] val;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_X_START;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        sink_stall = 0;
        idles_on = 1'b1;

        col_first = -500;
        col_limit = 300;
        row_first = 240;
        row_limit = -250;
        col_step = 7;
        row_step = 15;
        iter_limit = 20;
        col_pos = col_first;
        row_pos = row_first;

        script = '{
            beat_row(1'b0, 1'b1, 1'b0, DOT_LAST, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            beat_row(1'b1, 1'b1, 1'b0, DOT_LAST, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            // single point frame
            cfg_row(CFG_X_START, 11'd0),
            cfg_row(CFG_X_END, 11'd1),
            cfg_row(CFG_X_STEP, 11'd1),
            cfg_row(CFG_Y_START, 11'd1),
            cfg_row(CFG_Y_END, 11'd0),
            cfg_row(CFG_Y_STEP, 11'd1),
            beat_row(1'b1, 1'b1, 1'b1, BLANK_MID, NL_FRAME),
            beat_row(1'b0, 1'b1, 1'b1, BLANK_MID, NL_FRAME),
            cfg_row(CFG_MAX_ITER, 11'd1),
            beat_row(1'b0, 1'b1, 1'b1, BLANK_MID, NL_FRAME),
            // empty frames
            cfg_row(CFG_X_END, 11'd0),
            beat_row(1'b0, 1'b1, 1'b0, NL_FRAME, NONE),
            beat_row(1'b1, 1'b1, 1'b0, NL_FRAME, NONE),
            cfg_row(CFG_X_END, 11'd1),
            cfg_row(CFG_Y_END, 11'd1),
            beat_row(1'b0, 1'b1, 1'b0, NL_FRAME, NONE),
            cfg_row(CFG_UNUSED, 11'h7FF),
            beat_row(1'b0, 1'b1, 1'b0, NL_FRAME, NONE),
            // widest frame, largest steps
            cfg_row(CFG_X_START, 11'h400),
            cfg_row(CFG_X_END, 11'h3FF),
            cfg_row(CFG_Y_START, 11'h3FF),
            cfg_row(CFG_Y_END, 11'h400),
            cfg_row(CFG_X_STEP, 11'd255),
            cfg_row(CFG_Y_STEP, 11'd255),
            cfg_row(CFG_MAX_ITER, 11'd255),
            beat_row(1'b1, 1'b0, 1'b0, NONE, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            beat_row(1'b0, 1'b0, 1'b0, NONE, NONE),
            // point that never escapes, full iteration budget
            cfg_row(CFG_X_START, 11'd0),
            cfg_row(CFG_X_END, 11'd1),
            cfg_row(CFG_Y_START, 11'd1),
            cfg_row(CFG_Y_END, 11'd0),
            beat_row(1'b1, 1'b1, 1'b1, BLANK_MID, NL_FRAME)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(script[i].index, script[i].value);
            end
            else
                send_beat(script[i].restart, gap_len(), script[i].typed,
                          script[i].two_beats, script[i].first, script[i].second);
        end

        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            wait_idle();
            if ($urandom_range(0, 9) < 2)
            begin
                // single register change; often leaves the position stale
                idx = cfg_index_t'($urandom_range(0, 6));
                if (idx <= CFG_Y_END)
                    val = COORD_W'($urandom_range(0, 2047));
                else
                    val = COORD_W'($urandom_range(1, 60));
                write_reg(idx, val);
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    lo = $urandom_range(0, 600) - 500;
                    hi = $urandom_range(0, 500) - 250;
                end
                else
                begin
                    lo = $urandom_range(0, 2046) - 1024;
                    hi = $urandom_range(0, 2046) - 1023;
                end
                write_reg(CFG_X_START, COORD_W'(lo));
                lo = lo + $urandom_range(1, 300);
                write_reg(CFG_X_END, COORD_W'((lo > 1023) ? 1023 : lo));
                write_reg(CFG_Y_START, COORD_W'(hi));
                hi = hi - $urandom_range(1, 300);
                write_reg(CFG_Y_END, COORD_W'((hi < -1024) ? -1024 : hi));
                write_reg(CFG_X_STEP, ($urandom_range(0, 9) == 0) ?
                          COORD_W'(255) : COORD_W'($urandom_range(1, 60)));
                write_reg(CFG_Y_STEP, ($urandom_range(0, 9) == 0) ?
                          COORD_W'(255) : COORD_W'($urandom_range(1, 60)));
                lo = $urandom_range(0, 9);
                if (lo < 6)
                    write_reg(CFG_MAX_ITER, COORD_W'($urandom_range(1, 30)));
                else if (lo < 9)
                    write_reg(CFG_MAX_ITER, COORD_W'($urandom_range(31, 80)));
                else
                    write_reg(CFG_MAX_ITER, COORD_W'($urandom_range(81, 255)));
            end
            idles_on = ($urandom_range(0, 3) != 0);
            phase_beats = (iter_limit > 80) ? $urandom_range(8, 20) : $urandom_range(30, 90);
            repeat (phase_beats)
            begin
                send_beat($urandom_range(0, 15) == 0, gap_len(), 1'b0, 1'b0, NONE, NONE);
                sent++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
design/mar_pkg.sv
design/mar_escape_unit.sv
design/mandelbrot_ascii_raster_unit.sv
test/mandelbrot_ascii_raster_unit_test.sv
